/* src/hsl_color_tolerance_check_unit_defines.svh */
// assertion macros for the top-level rtl file
`ifndef HSL_COLOR_TOLERANCE_CHECK_UNIT_DEFINES_SVH
`define HSL_COLOR_TOLERANCE_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define HSL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hsl check failed");
`define HSL_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hsl reset check failed");
`else
`define HSL_ASSERT(lbl, prop)
`define HSL_ASSERT_RST(lbl, prop)
`endif

`endif

/* src/hsl_ct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hsl_ct_pkg;

    localparam int HSL_MAX_DEF = 240;
    localparam int COMP_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int DEN_W       = 12;
    localparam int COMP_MAX    = 255;
    localparam int SUM_MAX     = 510;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STD_HUE       = 3'd0,
        CFG_STD_SAT       = 3'd1,
        CFG_STD_LIGHT     = 3'd2,
        CFG_HUE_TOL       = 3'd3,
        CFG_SAT_TOL       = 3'd4,
        CFG_LIGHT_TOL     = 3'd5,
        CFG_LOW_SAT_LIMIT = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

/* src/hsl_ct_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per register stage
module hsl_ct_div #(
    parameter int NW = 20,
    parameter int DW = 12,
    parameter int QW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [NW-1:0] w_rem_in;
            logic [DW-1:0] w_den_in;
            logic [QW-1:0] w_quo_in;
            logic [NW-1:0] w_trial;
            logic          w_bit;

            if (k == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_den_in = r_den[k-1];
                assign w_quo_in = r_quo[k-1];
            end

            assign w_trial = NW'(w_den_in) << (QW - 1 - k);
            assign w_bit   = (w_rem_in >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k] <= (w_quo_in << 1) | QW'(w_bit);
                end
            end

            if (k < QW - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k] <= w_bit ? (w_rem_in - w_trial) : w_rem_in;
                        r_den[k] <= w_den_in;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

/* src/hsl_color_tolerance_check_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSL converter with a tolerance check against a programmed standard
// color. One pixel word enters and one result word leaves per clock unless
// stalled. Pixels pass stage a, stage b, the restoring dividers (one quotient
// bit per stage) and the output stage. The whole pipeline holds while a result
// waits under o_stall-back from i_stall. Registers are written through the cfg
// port (always ready) only while idle, a rule the block itself does not enforce.
module hsl_color_tolerance_check_unit #(
    parameter int HSL_MAX = hsl_ct_pkg::HSL_MAX_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [hsl_ct_pkg::COMP_W-1:0]    i_red,
    input  wire logic [hsl_ct_pkg::COMP_W-1:0]    i_green,
    input  wire logic [hsl_ct_pkg::COMP_W-1:0]    i_blue,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [hsl_ct_pkg::COMP_W-1:0]         o_hue,
    output logic [hsl_ct_pkg::COMP_W-1:0]         o_saturation,
    output logic [hsl_ct_pkg::COMP_W-1:0]         o_lightness,
    output logic                                  o_matches_res,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hsl_ct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hsl_ct_pkg::COMP_W-1:0]    i_cfg_data
);

    localparam int CW     = hsl_ct_pkg::COMP_W;
    localparam int DW     = hsl_ct_pkg::DEN_W;
    localparam int QW     = $clog2(HSL_MAX + 1);
    localparam int NW_VAL = $clog2(3060 * HSL_MAX + 1532);
    localparam int NW     = (NW_VAL > DW + QW) ? NW_VAL : DW + QW;

    // configuration
    logic [CW-1:0] r_std_hue, r_std_sat, r_std_light;
    logic [CW-1:0] r_hue_tol, r_sat_tol, r_light_tol, r_low_sat_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std_hue       <= '0;
            r_std_sat       <= '0;
            r_std_light     <= '0;
            r_hue_tol       <= '0;
            r_sat_tol       <= '0;
            r_light_tol     <= '0;
            r_low_sat_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hsl_ct_pkg::t_cfg_idx'(i_cfg_index))
                hsl_ct_pkg::CFG_STD_HUE:       r_std_hue       <= i_cfg_data;
                hsl_ct_pkg::CFG_STD_SAT:       r_std_sat       <= i_cfg_data;
                hsl_ct_pkg::CFG_STD_LIGHT:     r_std_light     <= i_cfg_data;
                hsl_ct_pkg::CFG_HUE_TOL:       r_hue_tol       <= i_cfg_data;
                hsl_ct_pkg::CFG_SAT_TOL:       r_sat_tol       <= i_cfg_data;
                hsl_ct_pkg::CFG_LIGHT_TOL:     r_light_tol     <= i_cfg_data;
                hsl_ct_pkg::CFG_LOW_SAT_LIMIT: r_low_sat_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global pipeline advance
    logic w_en;
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    // stage a: max, min, range, sum
    logic [CW-1:0] w_mx, w_mn;
    logic [CW-1:0] r_a_r, r_a_g, r_a_b, r_a_d;
    logic [CW:0]   r_a_sum;
    logic          r_a_rmax, r_a_gmax, r_a_v;

    always_comb begin
        w_mx = i_red;
        w_mn = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue > w_mx)  w_mx = i_blue;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue < w_mn)  w_mn = i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_r    <= i_red;
            r_a_g    <= i_green;
            r_a_b    <= i_blue;
            r_a_d    <= w_mx - w_mn;
            r_a_sum  <= (CW+1)'(w_mx) + (CW+1)'(w_mn);
            r_a_rmax <= (i_red == w_mx);
            r_a_gmax <= (i_green == w_mx);
        end
    end

    // stage b: numerators and denominators
    logic [11:0]   w_n, w_nw;
    logic [CW:0]   w_sden;
    logic          w_grey;
    logic [NW-1:0] r_b_hnum, r_b_snum, r_b_lnum;
    logic [DW-1:0] r_b_hden, r_b_sden;
    logic          r_b_v;

    always_comb begin
        if (r_a_rmax) begin
            w_n = 12'(r_a_g) - 12'(r_a_b);
        end else if (r_a_gmax) begin
            w_n = (12'(r_a_d) << 1) + 12'(r_a_b) - 12'(r_a_r);
        end else begin
            w_n = (12'(r_a_d) << 2) + 12'(r_a_r) - 12'(r_a_g);
        end
        // negative sixths wrap by a full turn
        w_nw   = w_n[11] ? (w_n + 12'(r_a_d) * 12'd6) : w_n;
        w_sden = (r_a_sum < (CW+1)'(hsl_ct_pkg::COMP_MAX)) ? r_a_sum
               : (CW+1)'(hsl_ct_pkg::SUM_MAX) - r_a_sum;
        w_grey = (r_a_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_lnum <= NW'(r_a_sum) * NW'(HSL_MAX) + NW'(hsl_ct_pkg::COMP_MAX);
            if (w_grey) begin
                r_b_hnum <= '0;
                r_b_hden <= DW'(1);
                r_b_snum <= '0;
                r_b_sden <= DW'(1);
            end else begin
                r_b_hnum <= NW'(w_nw) * NW'(2 * HSL_MAX) + NW'(r_a_d) * NW'(6);
                r_b_hden <= DW'(r_a_d) * DW'(12);
                r_b_snum <= NW'(r_a_d) * NW'(2 * HSL_MAX) + NW'(w_sden);
                r_b_sden <= DW'(w_sden) << 1;
            end
        end
    end

    // dividers
    logic [QW-1:0] w_hue_q, w_sat_q, w_light_q;

    hsl_ct_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_hue (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (r_b_hnum), .i_den (r_b_hden), .o_quo (w_hue_q)
    );

    hsl_ct_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_sat (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (r_b_snum), .i_den (r_b_sden), .o_quo (w_sat_q)
    );

    // lightness divisor is fixed: reciprocal product, then delayed to line up
    localparam int     LS = NW + 9;
    localparam longint LK = ((longint'(1) << LS) + longint'(hsl_ct_pkg::SUM_MAX) - 1)
                          / longint'(hsl_ct_pkg::SUM_MAX);

    logic [2*NW:0] w_lprod;
    logic [QW-1:0] r_lq [QW];

    assign w_lprod = (2*NW+1)'(r_b_lnum) * (2*NW+1)'(LK);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lq[0] <= w_lprod[LS +: QW];
            for (int k = 1; k < QW; k++) begin
                r_lq[k] <= r_lq[k-1];
            end
        end
    end

    assign w_light_q = r_lq[QW-1];

    // window test with wrap around the period
    function automatic logic in_win(input logic [QW-1:0] v,
                                    input logic [CW-1:0] sv,
                                    input logic [CW-1:0] tol);
        logic signed [12:0] lo, hi, per, rv;
        lo  = $signed(13'(sv)) - $signed(13'(tol));
        hi  = $signed(13'(sv)) + $signed(13'(tol));
        per = $signed(13'(HSL_MAX));
        rv  = $signed(13'(v));
        if (lo <= 0) begin
            in_win = (rv >= per + lo) || (rv <= hi);
        end else if (hi >= per) begin
            in_win = (rv <= hi - per) || (rv >= lo);
        end else begin
            in_win = (rv >= lo) && (rv <= hi);
        end
    endfunction

    logic w_pass;
    always_comb begin
        if (r_std_sat < r_low_sat_limit) begin
            w_pass = in_win(w_light_q, r_std_light, r_light_tol) &&
                     in_win(w_sat_q, r_std_sat, r_sat_tol);
        end else begin
            w_pass = in_win(w_hue_q, r_std_hue, r_hue_tol);
        end
    end

    // output stage
    logic [QW-1:0] r_hue, r_sat, r_light;
    logic          r_pass, r_ov;
    logic [QW-1:0] r_vq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue   <= w_hue_q;
            r_sat   <= w_sat_q;
            r_light <= w_light_q;
            r_pass  <= w_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_vq  <= '0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_vq  <= (r_vq << 1) | QW'(r_b_v);
            r_ov  <= r_vq[QW-1];
        end
    end

    assign o_valid       = r_ov;
    assign o_hue         = CW'(r_hue);
    assign o_saturation  = CW'(r_sat);
    assign o_lightness   = CW'(r_light);
    assign o_matches_res = r_pass;

`include "hsl_color_tolerance_check_unit_defines.svh"

    `HSL_ASSERT(a_hue_range, o_valid |-> (r_hue <= QW'(HSL_MAX)))
    `HSL_ASSERT(a_sat_range, o_valid |-> (r_sat <= QW'(HSL_MAX)))
    `HSL_ASSERT(a_light_range, o_valid |-> (r_light <= QW'(HSL_MAX)))
    `HSL_ASSERT(a_grey_zero, (r_a_v && w_en && w_grey) |=> (r_b_hnum == '0 && r_b_snum == '0))
    `HSL_ASSERT_RST(a_reset_clear, !i_rst_n |=> (!o_valid && r_vq == '0))

endmodule

`default_nettype wire

/* sim/tb_hsl_color_tolerance_check_unit.sv */
`timescale 1ns / 1ps

module tb_hsl_color_tolerance_check_unit;

    localparam int HMAX      = hsl_ct_pkg::HSL_MAX_DEF;
    localparam int LATENCY   = 11;
    localparam int CYCLE_LIM = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] light;
        logic       match;
    } t_hsl;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
    logic       matches_res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    t_pixel pixel_q[$];
    t_hsl   expected_hsl_q[$];
    logic [7:0] std_hue_r, std_sat_r, std_light_r;
    logic [7:0] hue_tol_r, sat_tol_r, light_tol_r, low_sat_r;
    int errors;
    int cycles;
    int pixels_sent;
    int results_seen;
    int matches_seen;
    int hold_cycles;
    bit feed_on;
    logic in_taken;

    hsl_color_tolerance_check_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_hue         (hue),
        .o_saturation  (saturation),
        .o_lightness   (lightness),
        .o_matches_res (matches_res),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit tol_window(int real_v, int stdv, int tol);
        int lo;
        int hi;
        lo = stdv - tol;
        hi = stdv + tol;
        if (lo <= 0) return real_v >= HMAX + lo || real_v <= hi;
        if (hi >= HMAX) return real_v <= hi - HMAX || real_v >= lo;
        return real_v >= lo && real_v <= hi;
    endfunction

    function automatic t_hsl convert_pixel(t_pixel p);
        int r, g, b, mx, mn, d, sum, den, num, h, s, l;
        bit ok;
        t_hsl res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        mn = r;
        h = 0;
        s = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        l = (sum * HMAX + 255) / 510;
        if (d > 0) begin
            den = (sum < 255) ? sum : 510 - sum;
            s = (2 * d * HMAX + den) / (2 * den);
            if (r == mx) num = g - b;
            else if (g == mx) num = 2 * d + (b - r);
            else num = 4 * d + (r - g);
            if (num < 0) num += 6 * d;
            h = (2 * num * HMAX + 6 * d) / (12 * d);
        end
        if (std_sat_r < low_sat_r)
            ok = tol_window(l, std_light_r, light_tol_r) && tol_window(s, std_sat_r, sat_tol_r);
        else
            ok = tol_window(h, std_hue_r, hue_tol_r);
        res.hue = h[7:0];
        res.sat = s[7:0];
        res.light = l[7:0];
        res.match = ok;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    task automatic write_reg(hsl_ct_pkg::t_cfg_idx idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            hsl_ct_pkg::CFG_STD_HUE:       std_hue_r   = val;
            hsl_ct_pkg::CFG_STD_SAT:       std_sat_r   = val;
            hsl_ct_pkg::CFG_STD_LIGHT:     std_light_r = val;
            hsl_ct_pkg::CFG_HUE_TOL:       hue_tol_r   = val;
            hsl_ct_pkg::CFG_SAT_TOL:       sat_tol_r   = val;
            hsl_ct_pkg::CFG_LIGHT_TOL:     light_tol_r = val;
            hsl_ct_pkg::CFG_LOW_SAT_LIMIT: low_sat_r   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_standard(logic [7:0] sh, logic [7:0] ss, logic [7:0] sl,
                                logic [7:0] th, logic [7:0] ts, logic [7:0] tl,
                                logic [7:0] lim);
        write_reg(hsl_ct_pkg::CFG_STD_HUE, sh);
        write_reg(hsl_ct_pkg::CFG_STD_SAT, ss);
        write_reg(hsl_ct_pkg::CFG_STD_LIGHT, sl);
        write_reg(hsl_ct_pkg::CFG_HUE_TOL, th);
        write_reg(hsl_ct_pkg::CFG_SAT_TOL, ts);
        write_reg(hsl_ct_pkg::CFG_LIGHT_TOL, tl);
        write_reg(hsl_ct_pkg::CFG_LOW_SAT_LIMIT, lim);
    endtask

    task automatic drain;
        while (pixel_q.size() != 0 || in_valid || expected_hsl_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        int mode;
        mode = $urandom_range(0, 9);
        p = t_pixel'($urandom);
        if (mode == 0) begin
            p.green = p.red;
            p.blue = p.red;
        end else if (mode == 1) begin
            p.green = p.red;
        end else if (mode == 2) begin
            p.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return p;
    endfunction

    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_q.push_back({r, g, b});
    endtask

    // word taken at the last rising edge
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
        end
    end

    // driver: pops pending words, random gaps, holds payload while stalled
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (pixel_q.size() != 0 && feed_on && $urandom_range(0, 3) != 0) begin
                t_pixel p;
                p = pixel_q.pop_front();
                in_valid <= 1'b1;
                red <= p.red;
                green <= p.green;
                blue <= p.blue;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // accepted words: predict on acceptance
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            expected_hsl_q.push_back(convert_pixel({red, green, blue}));
            pixels_sent++;
        end
    end

    // receiver stall: mostly short gaps, some long, plus a forced hold-off
    int stall_left;
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            case ($urandom_range(0, 19))
                0: stall_left <= $urandom_range(20, 60);
                1, 2, 3: stall_left <= $urandom_range(1, 3);
                default: ;
            endcase
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_hsl_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_hsl want;
                want = expected_hsl_q.pop_front();
                if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
                if (saturation !== want.sat) report_mismatch("saturation", saturation, want.sat);
                if (lightness !== want.light) report_mismatch("lightness", lightness, want.light);
                if (matches_res !== want.match)
                    report_mismatch("matches_res", matches_res, want.match);
                if (want.match) matches_seen++;
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIM) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL hsl_color_tolerance_check_unit");
            $finish;
        end
    end

    initial begin
        int phase;
        errors = 0;
        cycles = 0;
        pixels_sent = 0;
        results_seen = 0;
        matches_seen = 0;
        hold_cycles = 0;
        stall_left = 0;
        feed_on = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        red = '0;
        green = '0;
        blue = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        std_hue_r = '0;
        std_sat_r = '0;
        std_light_r = '0;
        hue_tol_r = '0;
        sat_tol_r = '0;
        light_tol_r = '0;
        low_sat_r = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: greys, primaries, secondaries, hue near wrap, extremes
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hff, 8'hff, 8'hff);
        push_pixel(8'h80, 8'h80, 8'h80);
        push_pixel(8'hff, 8'h00, 8'h00);
        push_pixel(8'h00, 8'hff, 8'h00);
        push_pixel(8'h00, 8'h00, 8'hff);
        push_pixel(8'hff, 8'hff, 8'h00);
        push_pixel(8'h00, 8'hff, 8'hff);
        push_pixel(8'hff, 8'h00, 8'hff);
        push_pixel(8'hff, 8'h00, 8'h01);
        push_pixel(8'hff, 8'h00, 8'h02);
        push_pixel(8'h01, 8'h00, 8'h00);
        push_pixel(8'hfe, 8'hff, 8'hff);
        push_pixel(8'h7f, 8'h80, 8'h80);
        push_pixel(8'h55, 8'haa, 8'h00);
        push_pixel(8'h12, 8'h34, 8'h56);
        drain();

        // window touching zero, wrap at the top, low saturation path
        set_standard(8'd10, 8'd100, 8'd120, 8'd10, 8'd20, 8'd30, 8'd50);
        push_pixel(8'hff, 8'h00, 8'h00);
        push_pixel(8'hff, 8'h00, 8'h05);
        push_pixel(8'hff, 8'h40, 8'h00);
        push_pixel(8'h20, 8'h40, 8'hff);
        drain();
        set_standard(8'd235, 8'd20, 8'd120, 8'd10, 8'd20, 8'd30, 8'd200);
        push_pixel(8'h80, 8'h80, 8'h80);
        push_pixel(8'h90, 8'h70, 8'h80);
        push_pixel(8'hff, 8'hff, 8'hff);
        push_pixel(8'h00, 8'h00, 8'h00);
        drain();

        // random phases with a mix of settings including extremes
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_standard(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                1: set_standard(8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240);
                2: set_standard(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
                3: set_standard(8'd120, 8'd10, 8'd120, 8'd0, 8'd240, 8'd240, 8'd255);
                default: set_standard(8'($urandom_range(0, 255)), 8'($urandom_range(0, 240)),
                                      8'($urandom_range(0, 240)), 8'($urandom_range(0, 80)),
                                      8'($urandom_range(0, 120)), 8'($urandom_range(0, 120)),
                                      8'($urandom_range(0, 255)));
            endcase
            repeat (105) pixel_q.push_back(rand_pixel());
            if (phase == 2) hold_cycles = 200;
            drain();
        end

        $display("checked %0d pixels, %0d results, %0d within tolerance",
                 pixels_sent, results_seen, matches_seen);
        $display("covered grey, primary, wrap and low saturation cases over 11 settings");
        if (errors == 0) begin
            $display("PASS hsl_color_tolerance_check_unit");
        end else begin
            $display("FAIL hsl_color_tolerance_check_unit");
        end
        $finish;
    end

endmodule
